[rtl/ipv4_src_and_tcp_port_packet_filter_unit_defines.svh]
// Assertion macros used by the filter top module.
`ifndef IPV4_SRC_AND_TCP_PORT_PACKET_FILTER_UNIT_DEFINES_SVH
`define IPV4_SRC_AND_TCP_PORT_PACKET_FILTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on clk_i, off while rst_ni is low.
`define IPFL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on clk_i at every edge, reset included.
`define IPFL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define IPFL_ASSERT(label, prop, msg)
`define IPFL_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[rtl/ipfl_pkg.sv]
// Types and constants of the IPv4 source and TCP port filter.
package ipfl_pkg;

  localparam int SLOT_W = 4;
  localparam int POS_W  = 6;

  localparam logic [15:0]      ETHTYPE_IPV4  = 16'h0800;
  localparam logic [7:0]       PROTO_NUM_TCP = 8'd6;
  localparam logic [POS_W-1:0] POS_MAX       = 6'd54;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_ADDR_WR = 2'd1,
    KIND_PORT_WR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_QUERY   = 2'd0,
    OP_ADDR_WR = 2'd1,
    OP_PORT_WR = 2'd2
  } tok_op_e;

  typedef enum logic [1:0] {
    REASON_NONE = 2'd0,
    REASON_SRC  = 2'd1,
    REASON_PORT = 2'd2
  } reason_e;

  // One accepted input item.
  typedef struct packed {
    kind_e             kind;
    logic [7:0]        data_byte;
    logic              last_byte;
    logic [SLOT_W-1:0] rule_slot;
    logic [31:0]       rule_key;
    logic              rule_valid;
    logic              rule_drop;
  } in_item_t;

  // Item travelling down the rule cell chain: a rule write or a frame query.
  typedef struct packed {
    logic              vld;
    tok_op_e           op;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       key;
    logic              rvalid;
    logic              rdrop;
    logic [31:0]       src;
    logic [31:0]       dst;
    logic [7:0]        proto;
    logic [15:0]       port;
    logic              ipv4_ok;
    logic              port_ok;
    logic              addr_hit;
    logic              port_hit;
  } tok_t;

endpackage

[rtl/ipfl_ifs.sv]
// Valid/ready channel interfaces for filter input items and verdicts.
interface ipfl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [3:0]  rule_slot;
  logic [31:0] rule_key;
  logic        rule_valid;
  logic        rule_drop;

  modport source (output valid, kind, data_byte, last_byte, rule_slot, rule_key,
                  rule_valid, rule_drop, input ready);
  modport sink (input valid, kind, data_byte, last_byte, rule_slot, rule_key,
                rule_valid, rule_drop, output ready);
endinterface

interface ipfl_out_if;
  logic        valid;
  logic        ready;
  logic        verdict;
  logic [1:0]  reason;
  logic        event_valid;
  logic [31:0] event_id;
  logic [31:0] src_address;
  logic [31:0] dst_address;
  logic [7:0]  protocol_number;

  modport source (output valid, verdict, reason, event_valid, event_id, src_address,
                  dst_address, protocol_number, input ready);
  modport sink (input valid, verdict, reason, event_valid, event_id, src_address,
                dst_address, protocol_number, output ready);
endinterface

[rtl/ipfl_parse.sv]
// Frame header capture; turns each item into a token for the rule chain.
module ipfl_parse (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  ipfl_pkg::in_item_t item_i,
  output ipfl_pkg::tok_t   tok_o
);
  import ipfl_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d, pos_nx;
  logic [15:0]      eth_q, eth_d, eth_upd;
  logic [7:0]       proto_q, proto_d, proto_upd;
  logic [31:0]      src_q, src_d, src_upd;
  logic [31:0]      dst_q, dst_d, dst_upd;
  logic [15:0]      port_q, port_d, port_upd;
  logic             byte_fire;

  assign byte_fire = fire_i && (item_i.kind == KIND_BYTE);
  assign pos_nx    = (pos_q < POS_MAX) ? pos_q + 1'b1 : pos_q;

  // Header fields including the byte now being taken.
  always_comb begin
    eth_upd   = eth_q;
    proto_upd = proto_q;
    src_upd   = src_q;
    dst_upd   = dst_q;
    port_upd  = port_q;
    if (pos_q == 6'd12 || pos_q == 6'd13) begin
      eth_upd = {eth_q[7:0], item_i.data_byte};
    end else if (pos_q == 6'd23) begin
      proto_upd = item_i.data_byte;
    end else if (pos_q >= 6'd26 && pos_q <= 6'd29) begin
      src_upd = {src_q[23:0], item_i.data_byte};
    end else if (pos_q >= 6'd30 && pos_q <= 6'd33) begin
      dst_upd = {dst_q[23:0], item_i.data_byte};
    end else if (pos_q == 6'd36 || pos_q == 6'd37) begin
      port_upd = {port_q[7:0], item_i.data_byte};
    end
  end

  // Update the capture on each byte taken; clear it at frame end.
  always_comb begin
    pos_d   = pos_q;
    eth_d   = eth_q;
    proto_d = proto_q;
    src_d   = src_q;
    dst_d   = dst_q;
    port_d  = port_q;
    if (byte_fire) begin
      if (item_i.last_byte) begin
        pos_d   = '0;
        eth_d   = '0;
        proto_d = '0;
        src_d   = '0;
        dst_d   = '0;
        port_d  = '0;
      end else begin
        pos_d   = pos_nx;
        eth_d   = eth_upd;
        proto_d = proto_upd;
        src_d   = src_upd;
        dst_d   = dst_upd;
        port_d  = port_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      eth_q   <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      port_q  <= '0;
    end else begin
      pos_q   <= pos_d;
      eth_q   <= eth_d;
      proto_q <= proto_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
      port_q  <= port_d;
    end
  end

  always_comb begin
    tok_o          = '0;
    tok_o.slot     = item_i.rule_slot;
    tok_o.key      = item_i.rule_key;
    tok_o.rvalid   = item_i.rule_valid;
    tok_o.rdrop    = item_i.rule_drop;
    tok_o.src      = src_upd;
    tok_o.dst      = dst_upd;
    tok_o.proto    = proto_upd;
    tok_o.port     = port_upd;
    tok_o.ipv4_ok  = (pos_q >= 6'd33) && (eth_upd == ETHTYPE_IPV4);
    tok_o.port_ok  = (proto_upd == PROTO_NUM_TCP) && (pos_q >= 6'd53) && (port_upd != 16'd0);
    tok_o.addr_hit = 1'b0;
    tok_o.port_hit = 1'b0;
    case (item_i.kind)
      KIND_BYTE: begin
        tok_o.vld = fire_i && item_i.last_byte;
        tok_o.op  = OP_QUERY;
      end
      KIND_ADDR_WR: begin
        tok_o.vld = fire_i;
        tok_o.op  = OP_ADDR_WR;
      end
      KIND_PORT_WR: begin
        tok_o.vld = fire_i;
        tok_o.op  = OP_PORT_WR;
      end
      default: begin
        tok_o.vld = 1'b0;
        tok_o.op  = OP_QUERY;
      end
    endcase
  end

endmodule

[rtl/ipfl_cell.sv]
// One rule cell: holds one address rule and one port rule (as HAS_ADDR/HAS_PORT allow), passes the item on.
module ipfl_cell #(
  parameter int IDX      = 0,
  parameter bit HAS_ADDR = 1'b1,
  parameter bit HAS_PORT = 1'b1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  ipfl_pkg::tok_t tok_i,
  output ipfl_pkg::tok_t tok_o
);
  import ipfl_pkg::*;

  localparam bit SLOT_OK = IDX < (1 << SLOT_W);
  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

  logic [31:0] akey_q;
  logic        aval_q, adrop_q;
  logic [15:0] pkey_q;
  logic        pval_q, pdrop_q;
  tok_t        tok_q, tok_d;
  logic        slot_hit, a_wr, p_wr;

  assign slot_hit = SLOT_OK && (tok_i.slot == MY_SLOT);
  assign a_wr = en_i && tok_i.vld && (tok_i.op == OP_ADDR_WR) && slot_hit && HAS_ADDR;
  assign p_wr = en_i && tok_i.vld && (tok_i.op == OP_PORT_WR) && slot_hit && HAS_PORT;

  // Fold this cell's match into a passing query.
  always_comb begin
    tok_d = tok_i;
    if (tok_i.op == OP_QUERY) begin
      tok_d.addr_hit = tok_i.addr_hit |
                       (HAS_ADDR && aval_q && adrop_q && (akey_q == tok_i.src));
      tok_d.port_hit = tok_i.port_hit |
                       (HAS_PORT && pval_q && pdrop_q && (pkey_q == tok_i.port));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aval_q  <= 1'b0;
      adrop_q <= 1'b0;
      pval_q  <= 1'b0;
      pdrop_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      if (a_wr) begin
        aval_q  <= tok_i.rvalid;
        adrop_q <= tok_i.rdrop;
      end
      if (p_wr) begin
        pval_q  <= tok_i.rvalid;
        pdrop_q <= tok_i.rdrop;
      end
      if (en_i) begin
        tok_q <= tok_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_wr) begin
      akey_q <= tok_i.key;
    end
    if (p_wr) begin
      pkey_q <= tok_i.key[15:0];
    end
  end

  assign tok_o = tok_q;

endmodule

[rtl/ipv4_src_and_tcp_port_packet_filter_unit.sv]
// A frame's query passes through the rule cell registers and then the output register.
// Throughput: one item per cycle; the rule cell chain and output register advance together
// and hold only while a verdict waits to be taken.
// Rule writes travel down the same chain, so each frame sees exactly the writes before it.
// Reset (rst_ni low, asynchronous): all rules invalid, header capture, event count cleared.
// No clearing pass is needed; ready is high and items are taken as soon as reset is released.
module ipv4_src_and_tcp_port_packet_filter_unit #(
  parameter int ADDR_RULES = 16,
  parameter int PORT_RULES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  ipfl_in_if.sink    in_i,
  ipfl_out_if.source out_o
);
  import ipfl_pkg::*;
  `include "ipv4_src_and_tcp_port_packet_filter_unit_defines.svh"

  localparam int NCELL = (ADDR_RULES > PORT_RULES) ? ADDR_RULES : PORT_RULES;

  in_item_t    item;
  tok_t        chain [NCELL+1];
  tok_t        tail;
  logic        adv, fire, res_vld;
  logic        out_vld_q;
  logic        verdict_d, verdict_q;
  reason_e     reason_d, reason_q;
  logic        ev_d, ev_q;
  logic [31:0] eid_d, eid_q;
  logic [31:0] sa_d, sa_q, da_d, da_q;
  logic [7:0]  pr_d, pr_q;
  logic [31:0] evt_cnt_q, evt_cnt_d;

  // Advance the whole chain unless a verdict is stuck at the output.
  assign adv  = !out_vld_q || out_o.ready;
  assign fire = in_i.valid && adv;
  assign in_i.ready = adv;

  assign item.kind       = kind_e'(in_i.kind);
  assign item.data_byte  = in_i.data_byte;
  assign item.last_byte  = in_i.last_byte;
  assign item.rule_slot  = in_i.rule_slot;
  assign item.rule_key   = in_i.rule_key;
  assign item.rule_valid = in_i.rule_valid;
  assign item.rule_drop  = in_i.rule_drop;

  ipfl_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item),
    .tok_o  (chain[0])
  );

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    ipfl_cell #(
      .IDX      (g),
      .HAS_ADDR (g < ADDR_RULES),
      .HAS_PORT (g < PORT_RULES)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .tok_i  (chain[g]),
      .tok_o  (chain[g+1])
    );
  end

  assign tail    = chain[NCELL];
  assign res_vld = tail.vld && (tail.op == OP_QUERY);

  always_comb begin
    verdict_d = 1'b0;
    reason_d  = REASON_NONE;
    ev_d      = 1'b0;
    eid_d     = '0;
    sa_d      = '0;
    da_d      = '0;
    pr_d      = '0;
    evt_cnt_d = evt_cnt_q;
    if (tail.ipv4_ok) begin
      sa_d = tail.src;
      da_d = tail.dst;
      pr_d = tail.proto;
      if (tail.addr_hit) begin
        verdict_d = 1'b1;
        reason_d  = REASON_SRC;
        ev_d      = 1'b1;
        eid_d     = evt_cnt_q + 32'd1;
        if (adv && res_vld) begin
          evt_cnt_d = evt_cnt_q + 32'd1;
        end
      end else if (tail.port_ok && tail.port_hit) begin
        verdict_d = 1'b1;
        reason_d  = REASON_PORT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      evt_cnt_q <= '0;
    end else begin
      evt_cnt_q <= evt_cnt_d;
      if (adv) begin
        out_vld_q <= res_vld;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_vld) begin
      verdict_q <= verdict_d;
      reason_q  <= reason_d;
      ev_q      <= ev_d;
      eid_q     <= eid_d;
      sa_q      <= sa_d;
      da_q      <= da_d;
      pr_q      <= pr_d;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.verdict         = verdict_q;
  assign out_o.reason          = reason_q;
  assign out_o.event_valid     = ev_q;
  assign out_o.event_id        = eid_q;
  assign out_o.src_address     = sa_q;
  assign out_o.dst_address     = da_q;
  assign out_o.protocol_number = pr_q;

  `IPFL_ASSERT(a_evt_reason,
      out_o.valid && out_o.event_valid |-> out_o.verdict && (out_o.reason == REASON_SRC),
      "event without source drop")
  `IPFL_ASSERT(a_pass_clean,
      out_o.valid && !out_o.verdict |-> (out_o.reason == REASON_NONE) && !out_o.event_valid,
      "pass verdict carries reason or event")
  `IPFL_ASSERT(a_cnt_step,
      !$stable(evt_cnt_q) |-> evt_cnt_q == $past(evt_cnt_q) + 32'd1,
      "event count skipped")
  `IPFL_ASSERT(a_evt_id,
      out_o.valid && out_o.event_valid |-> out_o.event_id == evt_cnt_q,
      "event number out of step with count")
  `IPFL_ASSERT_ALWAYS(a_rst_idle, !rst_ni |-> !out_o.valid, "verdict shown in reset")

endmodule
